// ===== hw/rtl/spq_pkg.sv =====
// Package for the sorted priority queue: payload types, codes, states and defaults.
`default_nettype none

package spq_pkg;

	localparam int SPQ_DEPTH = 64;
	localparam int OCC_W     = 7;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_POP    = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] in_x;
		logic [15:0] in_y;
		logic [31:0] in_cost;
		logic [31:0] in_priority;
	} spq_req_t;

	typedef struct packed {
		logic [15:0]      out_x;
		logic [15:0]      out_y;
		logic [31:0]      out_cost;
		logic [31:0]      out_priority;
		logic [1:0]       status;
		logic [OCC_W-1:0] occupancy;
		logic             is_empty;
	} spq_rsp_t;

	// One stored slot: ordering key and the carried payload.
	typedef struct packed {
		logic [31:0] prio;
		logic [15:0] x;
		logic [15:0] y;
		logic [31:0] cost;
	} spq_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_INS_PUT,
		ST_POP_RD,
		ST_POP_WR,
		ST_FINISH
	} spq_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/spq_stream_if.sv =====
// Valid/ready stream interface carrying one item of a given payload type.
`default_nettype none

interface spq_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sorted_priority_queue.sv =====
// A clear, or an insert or pop that fails, goes from accept straight to the result state.
// Insert reads and compares each stored entry from the top down, moving it up one slot, then writes the new one.
// Pop reads each slot in turn and moves it down one slot.
// Throughput: one item at a time; the single read port of the slot memory and the
// one comparator set a read step and a compare step per slot. Reset empties the queue at once;
// slot contents are not cleared and are never read before written.
`default_nettype none

module sorted_priority_queue #(
	parameter int QUEUE_DEPTH = spq_pkg::SPQ_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	spq_stream_if.sink   req,
	spq_stream_if.source rsp
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	// Memory port between sequencer and slot store
	logic                mem_we;
	logic [AW-1:0]       mem_waddr, mem_raddr;
	spq_pkg::spq_entry_t mem_wdata, mem_rdata;

	// Result hand-off from sequencer to output register
	logic              res_valid, res_ready;
	spq_pkg::spq_rsp_t res;

	// Output register
	logic              out_valid_q;
	spq_pkg::spq_rsp_t rsp_q;

	spq_core #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req       (req.payload),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	spq_mem #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Take a new result whenever the register is empty or its item leaves this cycle.
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	// Hold the payload while the sink stalls.
	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = rsp_q;

endmodule

`default_nettype wire

// ===== hw/rtl/spq_mem.sv =====
// Slot memory: one write port and one registered read port.
`default_nettype none

module spq_mem #(
	parameter int QUEUE_DEPTH = spq_pkg::SPQ_DEPTH,
	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
	input  wire logic               clk,
	input  wire logic               we,
	input  wire logic [AW-1:0]      waddr,
	input  wire spq_pkg::spq_entry_t wdata,
	input  wire logic [AW-1:0]      raddr,
	output      spq_pkg::spq_entry_t rdata
);

	spq_pkg::spq_entry_t mem_q [QUEUE_DEPTH];
	spq_pkg::spq_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/spq_core.sv =====
// Sequencer with the single priority comparator: walks the slot memory to insert or pop.
`default_nettype none

module spq_core #(
	parameter int QUEUE_DEPTH = spq_pkg::SPQ_DEPTH,
	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output      logic                req_ready,
	input  wire spq_pkg::spq_req_t   req,
	output      logic                res_valid,
	input  wire logic                res_ready,
	output      spq_pkg::spq_rsp_t   res,
	output      logic                mem_we,
	output      logic [AW-1:0]       mem_waddr,
	output      spq_pkg::spq_entry_t mem_wdata,
	output      logic [AW-1:0]       mem_raddr,
	input  wire spq_pkg::spq_entry_t mem_rdata
);

	spq_pkg::spq_state_t state_q, state_d;
	logic [1:0]          cmd_q, status_q, status_d;
	logic [CW-1:0]       k_q, count_q, res_count;
	logic [CW-1:0]       k_dec, k_inc;
	spq_pkg::spq_entry_t new_q, pop_q;
	logic                full, empty, ge;

	assign full  = (count_q == CW'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign k_dec = k_q - CW'(1);
	assign k_inc = k_q + CW'(1);
	// The single compare unit: does the stored entry sort at or after the new one?
	assign ge    = (mem_rdata.prio >= new_q.prio);

	always_comb begin
		unique case (req.command)
			spq_pkg::CMD_INSERT: status_d = full  ? spq_pkg::STAT_FULL  : spq_pkg::STAT_OK;
			spq_pkg::CMD_POP:    status_d = empty ? spq_pkg::STAT_EMPTY : spq_pkg::STAT_OK;
			default:             status_d = spq_pkg::STAT_OK;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			spq_pkg::ST_IDLE: begin
				if (req_valid) begin
					priority if (req.command == spq_pkg::CMD_INSERT && !full) begin
						state_d = empty ? spq_pkg::ST_INS_PUT : spq_pkg::ST_INS_RD;
					end else if (req.command == spq_pkg::CMD_POP && !empty) begin
						state_d = spq_pkg::ST_POP_RD;
					end else begin
						state_d = spq_pkg::ST_FINISH;
					end
				end
			end
			spq_pkg::ST_INS_RD:  state_d = spq_pkg::ST_INS_CMP;
			spq_pkg::ST_INS_CMP: begin
				if (!ge) begin
					state_d = spq_pkg::ST_FINISH;
				end else if (k_q == CW'(1)) begin
					state_d = spq_pkg::ST_INS_PUT;
				end else begin
					state_d = spq_pkg::ST_INS_RD;
				end
			end
			spq_pkg::ST_INS_PUT: state_d = spq_pkg::ST_FINISH;
			spq_pkg::ST_POP_RD:  state_d = spq_pkg::ST_POP_WR;
			spq_pkg::ST_POP_WR: begin
				state_d = (k_inc == count_q) ? spq_pkg::ST_FINISH : spq_pkg::ST_POP_RD;
			end
			spq_pkg::ST_FINISH: begin
				if (res_ready) begin
					state_d = spq_pkg::ST_IDLE;
				end
			end
			default: state_d = spq_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		req_ready = 1'b0;
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = k_q[AW-1:0];
		mem_wdata = new_q;
		mem_raddr = k_q[AW-1:0];
		unique case (state_q)
			spq_pkg::ST_IDLE:   req_ready = 1'b1;
			spq_pkg::ST_INS_RD: mem_raddr = k_dec[AW-1:0];
			spq_pkg::ST_INS_CMP: begin
				// Either shift the stored entry up one slot or drop the new one in.
				mem_we = 1'b1;
				if (ge) begin
					mem_wdata = mem_rdata;
				end
			end
			spq_pkg::ST_INS_PUT: mem_we = 1'b1;
			spq_pkg::ST_POP_WR: begin
				mem_we    = (k_q != '0);
				mem_waddr = k_dec[AW-1:0];
				mem_wdata = mem_rdata;
			end
			spq_pkg::ST_FINISH: res_valid = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		res_count = count_q;
		if (status_q == spq_pkg::STAT_OK) begin
			unique case (cmd_q)
				spq_pkg::CMD_INSERT: res_count = k_inc - k_q + count_q;
				spq_pkg::CMD_POP:    res_count = count_q - CW'(1);
				spq_pkg::CMD_CLEAR:  res_count = '0;
				default:             res_count = count_q;
			endcase
		end
	end

	always_comb begin
		res.out_x        = pop_q.x;
		res.out_y        = pop_q.y;
		res.out_cost     = pop_q.cost;
		res.out_priority = pop_q.prio;
		res.status       = status_q;
		res.occupancy    = spq_pkg::OCC_W'(res_count);
		res.is_empty     = (res_count == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= spq_pkg::ST_IDLE;
			count_q  <= '0;
			cmd_q    <= spq_pkg::CMD_CLEAR;
			status_q <= spq_pkg::STAT_OK;
			k_q      <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				spq_pkg::ST_IDLE: begin
					if (req_valid) begin
						cmd_q    <= req.command;
						status_q <= status_d;
						k_q      <= (req.command == spq_pkg::CMD_INSERT) ? count_q : '0;
					end
				end
				spq_pkg::ST_INS_CMP: begin
					if (ge) begin
						k_q <= k_dec;
					end
				end
				spq_pkg::ST_POP_WR: k_q <= k_inc;
				spq_pkg::ST_FINISH: begin
					if (res_ready) begin
						count_q <= res_count;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == spq_pkg::ST_IDLE && req_valid) begin
			new_q <= '{prio: req.in_priority, x: req.in_x, y: req.in_y, cost: req.in_cost};
			pop_q <= '0;
		end else if (state_q == spq_pkg::ST_POP_WR && k_q == '0) begin
			pop_q <= mem_rdata;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/spq_checker.sv =====
// Port-level assertions for the sorted priority queue, bound to the top level.
`default_nettype none

module spq_checker #(
	parameter int QUEUE_DEPTH = spq_pkg::SPQ_DEPTH
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_valid,
	input wire logic              req_ready,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire spq_pkg::spq_rsp_t rsp_payload
);

	// The sequencer never takes two items in consecutive cycles.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken again right after an accept");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_payload.is_empty == (rsp_payload.occupancy == '0)))
		else $error("empty flag disagrees with occupancy");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.status == spq_pkg::STAT_FULL
		|-> rsp_payload.occupancy == spq_pkg::OCC_W'(QUEUE_DEPTH) && rsp_payload.out_priority == '0)
		else $error("dropped insert with queue not full");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.status == spq_pkg::STAT_EMPTY
		|-> rsp_payload.is_empty && rsp_payload.out_cost == '0)
		else $error("failed pop on a non-empty queue");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
		else $error("result item changed while stalled");

endmodule

bind sorted_priority_queue spq_checker #(
	.QUEUE_DEPTH(QUEUE_DEPTH)
) u_spq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_payload (rsp.payload)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the sorted priority queue: directed, fill/overflow and random traffic.
`timescale 1ns / 1ps

module tb_top;

	localparam int          DEPTH          = spq_pkg::SPQ_DEPTH;
	localparam int          HALF_PERIOD    = 4;
	localparam int          RESET_CYCLES   = 7;
	localparam int          RANDOM_ITEMS   = 560;
	// Slowest item: a pop from a full queue, plus the longest
	// sender gap and the longest receiver stall. Allow roughly ten times that.
	localparam int          WATCHDOG_LIMIT = 2500;
	localparam int          SETTLE_CYCLES  = 200;
	localparam int          REPORT_LIMIT   = 10;
	// Code 3 is not decoded by the block; it must leave the queue alone.
	localparam logic [1:0]  CMD_UNUSED     = 2'd3;

	logic clk = 1'b0;
	logic arst_n;

	spq_stream_if #(.payload_t(spq_pkg::spq_req_t)) req_ch ();
	spq_stream_if #(.payload_t(spq_pkg::spq_rsp_t)) rsp_ch ();

	sorted_priority_queue #(
		.QUEUE_DEPTH(DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Queue model: slots kept sorted ascending by priority, slot 0 leaves
	// first. Updated once per accepted request item.
	// ------------------------------------------------------------------
	spq_pkg::spq_entry_t model_slot [DEPTH];
	int unsigned         model_count;

	spq_pkg::spq_rsp_t   pending_results [$];

	int unsigned items_sent;
	int unsigned results_checked;
	int unsigned mismatches;
	int unsigned idle_cycles;
	int unsigned inserts_seen, pops_seen, clears_seen, unused_seen;
	int unsigned dropped_full, popped_empty, peak_count;
	bit          sender_quiet;
	bit          req_taken, rsp_taken;

	// Apply one operation to the model and return the result it must produce.
	function automatic spq_pkg::spq_rsp_t apply_queue_op(input spq_pkg::spq_req_t op);
		spq_pkg::spq_rsp_t res;
		int unsigned       pos;
		int unsigned       k;
		res = '0;
		res.status = spq_pkg::STAT_OK;
		case (op.command)
			spq_pkg::CMD_INSERT: begin
				inserts_seen++;
				if (model_count >= DEPTH) begin
					// Full: drop the entry, leave the queue as it is.
					res.status = spq_pkg::STAT_FULL;
					dropped_full++;
				end else begin
					// Go in front of the first entry with equal or greater priority,
					// so the newest of a tie leaves first.
					pos = 0;
					while (pos < model_count && model_slot[pos].prio < op.in_priority)
						pos++;
					for (k = model_count; k > pos; k--)
						model_slot[k] = model_slot[k - 1];
					model_slot[pos].prio = op.in_priority;
					model_slot[pos].x    = op.in_x;
					model_slot[pos].y    = op.in_y;
					model_slot[pos].cost = op.in_cost;
					model_count++;
				end
			end
			spq_pkg::CMD_POP: begin
				pops_seen++;
				if (model_count == 0) begin
					res.status = spq_pkg::STAT_EMPTY;
					popped_empty++;
				end else begin
					res.out_x        = model_slot[0].x;
					res.out_y        = model_slot[0].y;
					res.out_cost     = model_slot[0].cost;
					res.out_priority = model_slot[0].prio;
					for (k = 1; k < model_count; k++)
						model_slot[k - 1] = model_slot[k];
					model_count--;
				end
			end
			spq_pkg::CMD_CLEAR: begin
				clears_seen++;
				model_count = 0;
			end
			default: begin
				unused_seen++;
			end
		endcase
		if (model_count > peak_count)
			peak_count = model_count;
		res.occupancy = spq_pkg::OCC_W'(model_count);
		res.is_empty  = (model_count == 0);
		return res;
	endfunction

	task automatic report_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("[%0t] mismatch on %s after %0d results: expected %h, got %h",
				$realtime, field, results_checked, want, got);
	endtask

	task automatic check_result(input spq_pkg::spq_rsp_t got);
		spq_pkg::spq_rsp_t want;
		if (pending_results.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("[%0t] result arrived with nothing outstanding: %p", $realtime, got);
			return;
		end
		want = pending_results.pop_front();
		results_checked++;
		if (got.out_x !== want.out_x)
			report_field("out_x", 32'(want.out_x), 32'(got.out_x));
		if (got.out_y !== want.out_y)
			report_field("out_y", 32'(want.out_y), 32'(got.out_y));
		if (got.out_cost !== want.out_cost)
			report_field("out_cost", want.out_cost, got.out_cost);
		if (got.out_priority !== want.out_priority)
			report_field("out_priority", want.out_priority, got.out_priority);
		if (got.status !== want.status)
			report_field("status", 32'(want.status), 32'(got.status));
		if (got.occupancy !== want.occupancy)
			report_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
		if (got.is_empty !== want.is_empty)
			report_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
	endtask

	// Predict on every accepted request, check every accepted result, and
	// end the run if the handshakes stop moving.
	always @(posedge clk) begin
		if (arst_n) begin
			req_taken = req_ch.valid && req_ch.ready;
			rsp_taken = rsp_ch.valid && rsp_ch.ready;
			if (req_taken)
				pending_results.push_back(apply_queue_op(req_ch.payload));
			if (rsp_taken)
				check_result(rsp_ch.payload);
			if (req_taken || rsp_taken)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
					idle_cycles, pending_results.size());
				$display("FAIL");
				$finish;
			end
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 2);
		else if (r < 95)
			return $urandom_range(3, 6);
		else
			return $urandom_range(10, 40);
	endfunction

	// Result side back-pressure: alternate runs of ready and stalls, with an
	// occasional long stretch of ready so the block runs unhindered.
	int unsigned ready_hold;

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			ready_hold = 0;
		end else if (ready_hold != 0) begin
			ready_hold--;
		end else if (rsp_ch.ready && $urandom_range(0, 2) != 0) begin
			rsp_ch.ready <= 1'b0;
			ready_hold = pick_gap();
		end else if ($urandom_range(0, 19) == 0) begin
			rsp_ch.ready <= 1'b1;
			ready_hold = 300;
		end else begin
			rsp_ch.ready <= 1'b1;
			ready_hold = $urandom_range(0, 30);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// Send one request item. Valid is left high on return so that a back-to-back
	// item follows without a gap; a later call that waits out a gap, or the end, drops it.
	task automatic send_item(input spq_pkg::spq_req_t item);
		int unsigned gap;
		gap = sender_quiet ? 0 : pick_gap();
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.payload <= item;
		do
			@(posedge clk);
		while (!req_ch.ready);
		items_sent++;
	endtask

	task automatic send_insert(input logic [15:0] x, input logic [15:0] y,
			input logic [31:0] cost, input logic [31:0] prio);
		spq_pkg::spq_req_t item;
		item.command     = spq_pkg::CMD_INSERT;
		item.in_x        = x;
		item.in_y        = y;
		item.in_cost     = cost;
		item.in_priority = prio;
		send_item(item);
	endtask

	// Non-insert commands carry random junk in the entry fields; it must be ignored.
	task automatic send_command(input logic [1:0] cmd);
		spq_pkg::spq_req_t item;
		item.command     = cmd;
		item.in_x        = 16'($urandom());
		item.in_y        = 16'($urandom());
		item.in_cost     = $urandom();
		item.in_priority = $urandom();
		send_item(item);
	endtask

	// Priorities drawn to give plenty of ties as well as the full range.
	function automatic logic [31:0] pick_priority();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return 32'($urandom_range(0, 7));
		else if (r < 8)
			return $urandom();
		else if (r == 8)
			return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
		else
			return $urandom_range(0, 1) ? 32'hFFFF_FFFE : 32'h0000_0001;
	endfunction

	task automatic send_random_insert();
		send_insert(16'($urandom()), 16'($urandom()), $urandom(), pick_priority());
	endtask

	// Field extremes, all commands, ties served newest first, pop on empty,
	// the unused command and clear.
	task automatic test_directed_ops();
		send_command(spq_pkg::CMD_POP);
		send_command(CMD_UNUSED);
		send_command(spq_pkg::CMD_CLEAR);
		send_insert(16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_insert(16'h0000, 16'hFFFF, 32'h0000_0000, 32'h0000_0000);
		send_insert(16'h0001, 16'h0001, 32'd100, 32'd5);
		send_insert(16'h0002, 16'h0002, 32'd200, 32'd5);
		send_insert(16'h0003, 16'h0003, 32'd300, 32'd5);
		send_insert(16'h0004, 16'h0004, 32'd400, 32'd4);
		send_command(CMD_UNUSED);
		repeat (4) send_command(spq_pkg::CMD_POP);
		// A later tie must overtake the one still queued.
		send_insert(16'h0005, 16'h0005, 32'd500, 32'd5);
		repeat (4) send_command(spq_pkg::CMD_POP);
		send_insert(16'hAAAA, 16'h5555, 32'hAAAA_AAAA, 32'h8000_0000);
		send_insert(16'h5555, 16'hAAAA, 32'h5555_5555, 32'h7FFF_FFFF);
		send_command(spq_pkg::CMD_CLEAR);
		send_command(spq_pkg::CMD_POP);
		send_insert(16'h1234, 16'h5678, 32'hDEAD_BEEF, 32'h0000_0000);
		send_command(spq_pkg::CMD_POP);
	endtask

	// Fill to the brim, push past it, drain and pop once more on empty;
	// both times with tie-heavy random priorities, first with sender gaps, then back-to-back.
	task automatic test_fill_to_overflow();
		repeat (2) begin
			send_command(spq_pkg::CMD_CLEAR);
			repeat (DEPTH + 2) send_random_insert();
			repeat (DEPTH + 1) send_command(spq_pkg::CMD_POP);
			sender_quiet = 1'b1;
		end
		// Refill and clear while full.
		repeat (DEPTH) send_random_insert();
		send_insert(16'($urandom()), 16'($urandom()), $urandom(), $urandom());
		send_command(spq_pkg::CMD_CLEAR);
		send_command(spq_pkg::CMD_POP);
		sender_quiet = 1'b0;
	endtask

	// Episodes that lean towards filling, draining or neither, so the
	// occupancy wanders over the whole range with rare clears and junk.
	task automatic test_random_traffic();
		int unsigned goal;
		int unsigned insert_pct;
		int unsigned r;
		goal = items_sent + RANDOM_ITEMS;
		while (items_sent < goal) begin
			case ($urandom_range(0, 2))
				0:       insert_pct = 82;
				1:       insert_pct = 14;
				default: insert_pct = 48;
			endcase
			sender_quiet = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(10, 80)) begin
				r = $urandom_range(0, 99);
				if (r < 2)
					send_command(spq_pkg::CMD_CLEAR);
				else if (r < 3)
					send_command(CMD_UNUSED);
				else if (r < 3 + insert_pct)
					send_random_insert();
				else
					send_command(spq_pkg::CMD_POP);
			end
		end
		sender_quiet = 1'b0;
	endtask

	task automatic finish_run();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// Let any stray result show itself before the verdict.
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Ran %0d items: %0d inserts (%0d dropped when full), %0d pops (%0d on empty),",
			items_sent, inserts_seen, dropped_full, pops_seen, popped_empty);
		$display("%0d clears, %0d unused commands; peak occupancy %0d; %0d results checked.",
			clears_seen, unused_seen, peak_count, results_checked);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches, %0d results never arrived",
				mismatches, pending_results.size());
			$display("FAIL");
		end
		$finish;
	endtask

	initial begin
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.payload = '0;
		sender_quiet   = 1'b0;
		items_sent     = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_ops();
		test_fill_to_overflow();
		test_random_traffic();
		finish_run();
	end

endmodule

// ===== sim.f =====
hw/rtl/spq_pkg.sv
hw/rtl/spq_stream_if.sv
hw/rtl/spq_mem.sv
hw/rtl/spq_core.sv
hw/rtl/sorted_priority_queue.sv
hw/rtl/spq_checker.sv
tb/sv/tb_top.sv
